// ===== hdl/rbwn_pkg.sv =====
package rbwn_pkg;

	localparam int ROW_LEN_MAX = 64;
	localparam int ROW_LEN_DEF = 64;
	localparam int SAMPLE_W = 16;
	localparam int SUM_W = 22;
	localparam int CENT_W = 18;
	// side total: up to 64 * 2^17
	localparam int TOT_W = 24;
	localparam int NUM_W = CENT_W + 15;
	localparam logic [TOT_W-1:0] TOTAL_ONE = TOT_W'(256);

	typedef struct packed {
		logic signed [15:0] sample;
		logic end_of_row;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] weight;
		logic last_in_row;
	} out_item_t;

	// row descriptor from the load side to the emit side
	typedef struct packed {
		logic [6:0] count;
		logic signed [SUM_W-1:0] sum;
		logic base;
	} row_desc_t;

endpackage

// ===== hdl/rbwn_ram.sv =====
module rbwn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/rbwn_divider.sv =====
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module rbwn_divider
	import rbwn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic signed [CENT_W-1:0] centered,
	input  logic [TOT_W-1:0] total,
	output logic done,
	output logic signed [15:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] q_q;
	logic [TOT_W:0] rem_q;
	logic [TOT_W-1:0] den_q;
	logic neg_q;
	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TOT_W:0] trial;
	logic [NUM_W:0] sq;
	logic [CENT_W-1:0] mag;

	assign mag = centered[CENT_W-1] ? CENT_W'(-centered) : centered;
	assign trial = {rem_q[TOT_W-1:0], num_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= {mag, 15'd0};
			den_q <= total;
			rem_q <= '0;
			q_q <= '0;
			neg_q <= centered[CENT_W-1];
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				q_q <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		sq = neg_q ? -{1'b0, q_q} : {1'b0, q_q};
		if (!neg_q && q_q > NUM_W'(32767)) quot = 16'sd32767;
		else if (neg_q && q_q > NUM_W'(32768)) quot = -16'sd32768;
		else quot = sq[15:0];
	end
endmodule

// ===== hdl/rbwn_front.sv =====
// Load side: write samples to the row buffer, accumulate, hand off finished rows.
module rbwn_front
	import rbwn_pkg::*;
#(
	parameter int ROW_LEN = ROW_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  in_item_t in_item,
	input  logic q_full,
	output logic busy,
	output logic wr_en,
	output logic [6:0] wr_addr,
	output logic push,
	output row_desc_t push_desc
);
	logic [6:0] count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic base_q;
	logic accept;
	logic row_end;
	logic [6:0] count_nx;

	assign busy = q_full;
	assign accept = start && !busy;
	assign count_nx = count_q + 7'd1;
	assign row_end = in_item.end_of_row || (count_nx >= 7'(ROW_LEN));
	assign wr_en = accept;
	assign wr_addr = {base_q, count_q[5:0]};
	assign push = accept && row_end;
	assign push_desc = '{count: count_nx,
		sum: sum_q + SUM_W'(in_item.sample), base: base_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			base_q <= 1'b0;
		end else if (accept) begin
			if (row_end) begin
				count_q <= '0;
				sum_q <= '0;
				base_q <= !base_q;
			end else begin
				count_q <= count_nx;
				sum_q <= sum_q + SUM_W'(in_item.sample);
			end
		end
	end

	property p_cnt_range;
		@(posedge clk) disable iff (!arst_n) count_q < 7'(ROW_LEN);
	endproperty
	a_cnt_range: assert property (p_cnt_range) else $error("row count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("push into full queue");
	a_flip: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> base_q != $past(base_q)) else $error("buffer half not swapped");
endmodule

// ===== hdl/rbwn_back.sv =====
// Emit side: mean, side totals pass, then one division per element.
module rbwn_back
	import rbwn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  row_desc_t q_desc,
	output logic pop,
	output logic [6:0] rd_addr,
	input  logic signed [SAMPLE_W-1:0] rd_data,
	output logic strobe,
	output out_item_t result
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MEAN = 3'd1;
	localparam logic [2:0] ST_SUM = 3'd2;
	localparam logic [2:0] ST_RD = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_WAIT = 3'd5;

	logic [2:0] state_q;
	row_desc_t desc_q;
	logic [6:0] idx_q;
	logic [6:0] sidx_q;
	logic rvalid_q;
	logic signed [SUM_W-1:0] mrem_q;
	logic signed [CENT_W-1:0] mean_q;
	logic [SUM_W-1:0] macc_q;
	logic [TOT_W-1:0] pos_q, neg_q;
	logic signed [CENT_W-1:0] cent;
	logic [TOT_W-1:0] tot;
	logic div_go, div_done;
	logic signed [15:0] quot;
	logic [SUM_W-1:0] sum_mag;
	logic [SUM_W-1:0] mtrial;

	assign cent = CENT_W'(rd_data) - mean_q;
	assign rd_addr = {desc_q.base, idx_q[5:0]};
	// release the row's buffer half only once its last weight is out
	assign pop = (state_q == ST_DIV) && div_done && (sidx_q + 7'd1 == desc_q.count);
	assign sum_mag = q_desc.sum[SUM_W-1] ? SUM_W'(-q_desc.sum) : SUM_W'(q_desc.sum);
	// mean by shift-and-subtract division by count, one quotient bit per cycle
	assign mtrial = {macc_q[SUM_W-2:0], 1'b0} | SUM_W'(mrem_q[SUM_W-1]);

	rbwn_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .centered(cent),
		.total(tot), .done(div_done), .quot(quot));

	assign tot = (cent > 0) ? (pos_q == '0 ? TOTAL_ONE : pos_q)
		: (neg_q == '0 ? TOTAL_ONE : neg_q);
	assign div_go = (state_q == ST_RD) && rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe <= 1'b0;
			idx_q <= '0;
			sidx_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (q_valid) begin
					state_q <= ST_MEAN;
					idx_q <= 7'(SUM_W);
				end
				ST_MEAN: begin
					idx_q <= idx_q - 7'd1;
					if (idx_q == 7'd1) begin
						state_q <= ST_SUM;
						idx_q <= '0;
						sidx_q <= '0;
						rvalid_q <= 1'b0;
					end
				end
				ST_SUM: begin
					rvalid_q <= idx_q < desc_q.count;
					if (idx_q < desc_q.count) idx_q <= idx_q + 7'd1;
					if (rvalid_q) sidx_q <= sidx_q + 7'd1;
					if (rvalid_q && sidx_q + 7'd1 == desc_q.count) begin
						state_q <= ST_RD;
						idx_q <= '0;
						sidx_q <= '0;
						rvalid_q <= 1'b0;
					end
				end
				ST_RD: begin
					if (rvalid_q) begin
						state_q <= ST_DIV;
						rvalid_q <= 1'b0;
					end else begin
						rvalid_q <= 1'b1;
					end
				end
				ST_DIV: if (div_done) begin
					strobe <= 1'b1;
					sidx_q <= sidx_q + 7'd1;
					idx_q <= idx_q + 7'd1;
					state_q <= (sidx_q + 7'd1 == desc_q.count) ? ST_IDLE : ST_RD;
				end
				ST_WAIT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			desc_q <= q_desc;
			mrem_q <= SUM_W'(sum_mag);
			macc_q <= '0;
			pos_q <= '0;
			neg_q <= '0;
		end
		if (state_q == ST_MEAN) begin
			// shift dividend bits into remainder, compare with count
			mrem_q <= mrem_q <<< 1;
			if (mtrial >= SUM_W'(desc_q.count)) begin
				macc_q <= mtrial - SUM_W'(desc_q.count);
				mean_q <= (mean_q <<< 1) | CENT_W'(1);
			end else begin
				macc_q <= mtrial;
				mean_q <= mean_q <<< 1;
			end
			if (idx_q == 7'(SUM_W)) mean_q <= '0;
			if (idx_q == 7'd1) begin
				if (mtrial >= SUM_W'(desc_q.count))
					mean_q <= desc_q.sum[SUM_W-1] ? -((mean_q <<< 1) | CENT_W'(1))
						: ((mean_q <<< 1) | CENT_W'(1));
				else
					mean_q <= desc_q.sum[SUM_W-1] ? -(mean_q <<< 1) : (mean_q <<< 1);
			end
		end
		if (state_q == ST_SUM && rvalid_q) begin
			if (cent > 0) pos_q <= pos_q + TOT_W'(cent);
			else neg_q <= neg_q + TOT_W'(-cent);
		end
		result.weight <= quot;
		result.last_in_row <= (sidx_q + 7'd1 == desc_q.count);
	end

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("stray divider result");
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(div_done)) else $error("result without division");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_IDLE) else $error("pop did not end row");
endmodule

// ===== hdl/row_balanced_weight_normalizer_core.sv =====
// Row-balanced weight normalizer.
// Input: start/busy command channel carrying in_item (sample, end_of_row).
// An item transfers on a clock edge with start high and busy low.
// Samples load one per cycle, unless busy, into one half of a double row
// buffer. A row ends on end_of_row or when ROW_LEN elements are held; its
// count and sum then go to a two-entry row queue, and loading continues in
// the other half. A queued row keeps its half until its last weight is out,
// so busy is high while two finished rows are held (one emitting, one waiting).
// Output: strobe marks result for one cycle; the receiver cannot stall.
// The emit side per row: the mean (an idle state, then a bit-serial division
// of the sum by count), a pass over the buffer for the side totals, then per
// element a buffer read plus a division of its centered value and its done
// pulse; one element is divided at a time. The divider sets the throughput.
// Reset clears counters, queue and state; buffer contents need no reset.
module row_balanced_weight_normalizer_core
	import rbwn_pkg::*;
#(
	parameter int ROW_LEN = ROW_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  in_item_t in_item,
	output logic busy,
	output logic strobe,
	output out_item_t result
);
	logic wr_en, push, pop;
	logic [6:0] wr_addr, rd_addr;
	row_desc_t push_desc;
	row_desc_t qd_q [2];
	logic [1:0] qcnt_q;
	logic qrd_q, qwr_q;
	logic [SAMPLE_W-1:0] rd_data;

	rbwn_front #(.ROW_LEN(ROW_LEN)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item),
		.q_full(qcnt_q == 2'd2), .busy(busy), .wr_en(wr_en), .wr_addr(wr_addr),
		.push(push), .push_desc(push_desc));

	rbwn_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 * ROW_LEN_MAX)) u_buf (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(in_item.sample),
		.raddr(rd_addr), .rdata(rd_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= '0;
			qrd_q <= 1'b0;
			qwr_q <= 1'b0;
		end else begin
			if (push) qwr_q <= !qwr_q;
			if (pop) qrd_q <= !qrd_q;
			qcnt_q <= qcnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) qd_q[qwr_q] <= push_desc;
	end

	rbwn_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(qcnt_q != 2'd0), .q_desc(qd_q[qrd_q]),
		.pop(pop), .rd_addr(rd_addr), .rd_data(rd_data),
		.strobe(strobe), .result(result));

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= 2'd2) else $error("row queue overflow");
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> qcnt_q == 2'd2) else $error("busy without full queue");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qcnt_q != 2'd0) else $error("pop from empty queue");
endmodule

// ===== tb/sv/tb_row_balanced_weight_normalizer_core.sv =====
`timescale 1ns / 1ps

module tb_row_balanced_weight_normalizer_core
	import rbwn_pkg::*;
();

	localparam int ROWS = 64;

	typedef struct {
		logic [15:0] sample;
		logic        eor;
		logic        has_exp;
		logic [15:0] exp_weight;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	in_item_t  in_item;
	logic      busy;
	logic      strobe;
	out_item_t result;

	row_balanced_weight_normalizer_core #(.ROW_LEN(ROWS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item),
		.busy(busy), .strobe(strobe), .result(result)
	);

	// predictor state
	logic signed [15:0] row_buf[ROWS];
	int unsigned        row_fill;
	longint             row_sum;

	out_item_t weight_q[$];
	logic [15:0] pinned_q[$];
	logic        pinned_valid_q[$];
	int errors;
	int n_items, n_weights, n_rows;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("** row_balanced_weight_normalizer_core: FAILED **");
		$finish;
	end

	// record one accepted sample; at row end push the row's expected weights
	task automatic predict_sample(input logic [15:0] smp, input logic eor,
			input logic has_exp, input logic [15:0] exp_w);
		longint mean, pos_tot, neg_tot, c, q, tot;
		int unsigned n;
		out_item_t o;
		begin
			row_buf[row_fill] = smp;
			row_fill++;
			row_sum += longint'($signed(smp));
			if (eor || row_fill >= ROWS) begin
				n = row_fill;
				mean = row_sum / longint'(n);
				pos_tot = 0;
				neg_tot = 0;
				for (int i = 0; i < n; i++) begin
					c = longint'(row_buf[i]) - mean;
					if (c > 0) pos_tot += c;
					else neg_tot -= c;
				end
				if (pos_tot == 0) pos_tot = 256;
				if (neg_tot == 0) neg_tot = 256;
				for (int i = 0; i < n; i++) begin
					c = longint'(row_buf[i]) - mean;
					tot = (c > 0) ? pos_tot : neg_tot;
					q = (c * 32768) / tot;
					if (q > 32767) q = 32767;
					if (q < -32768) q = -32768;
					o.weight = q[15:0];
					o.last_in_row = (i + 1 == n);
					weight_q.push_back(o);
					// pinned value applies to the weight of this sample
					pinned_valid_q.push_back(has_exp && (i + 1 == n));
					pinned_q.push_back(exp_w);
				end
				row_fill = 0;
				row_sum = 0;
				n_rows++;
			end
		end
	endtask

	// checker
	always @(posedge clk) begin
		out_item_t e;
		logic pv;
		logic [15:0] pw;
		if (arst_n && strobe) begin
			if (weight_q.size() == 0) begin
				$error("unexpected weight %0d", $signed(result.weight));
				errors++;
			end else begin
				e = weight_q.pop_front();
				pv = pinned_valid_q.pop_front();
				pw = pinned_q.pop_front();
				n_weights++;
				if (result.weight !== e.weight) begin
					$error("weight: expected %0d, actual %0d", $signed(e.weight),
						$signed(result.weight));
					errors++;
				end
				if (pv && result.weight !== pw) begin
					$error("weight (table): expected %0d, actual %0d", $signed(pw),
						$signed(result.weight));
					errors++;
				end
				if (result.last_in_row !== e.last_in_row) begin
					$error("last_in_row: expected %0b, actual %0b", e.last_in_row,
						result.last_in_row);
					errors++;
				end
			end
		end
	end

	bit calm;

	task automatic send(input logic [15:0] smp, input logic eor,
			input logic has_exp = 1'b0, input logic [15:0] exp_w = '0);
		begin
			while (!calm && $urandom_range(99) < 16) begin
				start <= 1'b0;
				@(posedge clk);
			end
			start <= 1'b1;
			in_item.sample <= smp;
			in_item.end_of_row <= eor;
			@(posedge clk);
			while (busy) @(posedge clk);
			predict_sample(smp, eor, has_exp, exp_w);
			n_items++;
		end
	endtask

	task automatic drain;
		begin
			start <= 1'b0;
			while (weight_q.size() != 0) @(posedge clk);
		end
	endtask

	stim_row_t dir[$];

	initial begin
		int len, mode;
		logic [15:0] s;
		errors = 0;
		n_items = 0;
		n_weights = 0;
		n_rows = 0;
		row_fill = 0;
		row_sum = 0;
		calm = 0;
		start = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element row: centered 0, neg total replaced by 256
		dir.push_back('{16'h7FFF, 1'b1, 1'b1, 16'h0000});
		dir.push_back('{16'h8000, 1'b1, 1'b1, 16'h0000});
		// two extremes: max side saturates to 0x7FFF, min gives exactly -1.0
		dir.push_back('{16'h8000, 1'b0, 1'b0, 16'h0});
		dir.push_back('{16'h7FFF, 1'b1, 1'b1, 16'h7FFF});
		dir.push_back('{16'h7FFF, 1'b0, 1'b0, 16'h0});
		dir.push_back('{16'h8000, 1'b1, 1'b1, 16'h8000});
		// mean truncation toward zero on a negative sum
		dir.push_back('{16'hFFFF, 1'b0, 1'b0, 16'h0});
		dir.push_back('{16'hFFFE, 1'b0, 1'b0, 16'h0});
		dir.push_back('{16'h0001, 1'b1, 1'b0, 16'h0});
		// all equal row: every centered value zero
		dir.push_back('{16'h0100, 1'b0, 1'b0, 16'h0});
		dir.push_back('{16'h0100, 1'b0, 1'b0, 16'h0});
		dir.push_back('{16'h0100, 1'b1, 1'b1, 16'h0000});
		dir.push_back('{16'h5555, 1'b0, 1'b0, 16'h0});
		dir.push_back('{16'hAAAA, 1'b1, 1'b0, 16'h0});
		foreach (dir[i]) send(dir[i].sample, dir[i].eor, dir[i].has_exp, dir[i].exp_weight);
		// full row without an end mark ends on its own
		for (int i = 0; i < ROWS; i++) send(16'($urandom), 1'b0);
		// hold off until everything is out
		drain;

		while (n_items < 470) begin
			calm = (n_items > 250 && n_items < 330);
			mode = $urandom_range(9);
			len = (mode < 6) ? $urandom_range(1, 8) :
				(mode < 9) ? $urandom_range(9, 40) : ROWS + 8;
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(3))
					0: s = 16'($urandom);
					1: s = 16'($signed($urandom_range(0, 64)) - 32);
					2: s = $urandom_range(1) ? 16'h7FFF : 16'h8000;
					default: s = 16'($urandom_range(0, 1023));
				endcase
				send(s, (i == len - 1) && (len <= ROWS));
			end
			if ($urandom_range(15) == 0) drain;
		end
		// close any open row
		if (row_fill != 0) send(16'h0000, 1'b1);
		drain;
		repeat (3000) @(posedge clk);
		$display("Sent %0d samples in %0d rows; checked %0d weights.", n_items, n_rows,
			n_weights);
		if (errors == 0 && weight_q.size() == 0)
			$display("** row_balanced_weight_normalizer_core: PASSED **");
		else
			$display("** row_balanced_weight_normalizer_core: FAILED **");
		$finish;
	end

endmodule
